// ----- rtl/kgd_pkg.sv -----
// kgd_pkg: shared types and constants of the key gesture detector
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package kgd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_CONFIRM_TICKS  = 3'd0,
		CFG_LONG_TICKS     = 3'd1,
		CFG_REPEAT_TICKS   = 3'd2,
		CFG_DOUBLE_PRESS   = 3'd3,
		CFG_DOUBLE_GAP     = 3'd4,
		CFG_DOUBLE_EN_MASK = 3'd5,
		CFG_SHIFT_EN_MASK  = 3'd6,
		CFG_REPEAT_EN_MASK = 3'd7
	} cfg_idx_t;

	// per key phase
	typedef enum logic [1:0] {
		PH_IDLE        = 2'd0,
		PH_PRESSED     = 2'd1,
		PH_WAIT_DOUBLE = 2'd2,
		PH_LONG        = 2'd3
	} phase_t;

	// event kinds
	typedef enum logic [2:0] {
		EV_PRESS        = 3'd0,
		EV_RELEASE      = 3'd1,
		EV_LONG         = 3'd2,
		EV_LONG_RELEASE = 3'd3,
		EV_DOUBLE       = 3'd4
	} ev_kind_t;

	localparam int unsigned KEY_W = 3;
	localparam int unsigned CNT_W = 8;
	localparam int unsigned REP_W = 6;
	localparam int unsigned MASK_W = 8;

	// press ticks a click needs before a press event is given
	localparam logic [CNT_W-1:0] MIN_PRESS_FOR_CLICK = 8'd2;

	typedef struct packed {
		logic [CNT_W-1:0]  confirm_ticks;
		logic [CNT_W-1:0]  long_press_ticks;
		logic [REP_W-1:0]  repeat_ticks;
		logic [CNT_W-1:0]  double_press_limit;
		logic [CNT_W-1:0]  double_gap_limit;
		logic [MASK_W-1:0] double_enable_mask;
		logic [MASK_W-1:0] shift_enable_mask;
		logic [MASK_W-1:0] repeat_enable_mask;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		ev_kind_t         kind;
		logic             shifted;
	} event_t;

endpackage

`default_nettype wire

// ----- rtl/kgd_cfg_regs.sv -----
// kgd_cfg_regs: configuration register file of the key gesture detector
// depends on kgd_pkg for the register index codes and the cfg_t bundle
`default_nettype none

module kgd_cfg_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [kgd_pkg::CNT_W-1:0] cfg_wdata,
	output kgd_pkg::cfg_t                  cfg
);

	kgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_ticks      <= 8'd3;
			cfg_q.long_press_ticks   <= 8'd50;
			cfg_q.repeat_ticks       <= 6'd10;
			cfg_q.double_press_limit <= 8'd15;
			cfg_q.double_gap_limit   <= 8'd15;
			cfg_q.double_enable_mask <= 8'd0;
			cfg_q.shift_enable_mask  <= 8'd0;
			cfg_q.repeat_enable_mask <= 8'd0;
		end else if (cfg_we) begin
			unique case (kgd_pkg::cfg_idx_t'(cfg_index))
				kgd_pkg::CFG_CONFIRM_TICKS:  cfg_q.confirm_ticks      <= cfg_wdata;
				kgd_pkg::CFG_LONG_TICKS:     cfg_q.long_press_ticks   <= cfg_wdata;
				kgd_pkg::CFG_REPEAT_TICKS:   cfg_q.repeat_ticks       <=
					cfg_wdata[kgd_pkg::REP_W-1:0];
				kgd_pkg::CFG_DOUBLE_PRESS:   cfg_q.double_press_limit <= cfg_wdata;
				kgd_pkg::CFG_DOUBLE_GAP:     cfg_q.double_gap_limit   <= cfg_wdata;
				kgd_pkg::CFG_DOUBLE_EN_MASK: cfg_q.double_enable_mask <= cfg_wdata;
				kgd_pkg::CFG_SHIFT_EN_MASK:  cfg_q.shift_enable_mask  <= cfg_wdata;
				kgd_pkg::CFG_REPEAT_EN_MASK: cfg_q.repeat_enable_mask <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/kgd_core.sv -----
// kgd_core: per key state store and the single pass gesture logic
// depends on kgd_pkg for phases, event kinds, cfg_t and event_t
`default_nettype none

module kgd_core #(
	parameter int unsigned NUM_KEYS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire kgd_pkg::cfg_t             cfg,
	input  wire logic                      step,
	input  wire logic [kgd_pkg::KEY_W-1:0] key,
	input  wire logic                      pressed,
	output logic [1:0]                     ev_cnt,
	output kgd_pkg::event_t                ev0,
	output kgd_pkg::event_t                ev1
);

	// only keys the 3 bit index can reach need storage
	localparam int unsigned KEY_DEPTH = (NUM_KEYS < 8) ? NUM_KEYS : 8;
	localparam int unsigned IDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

	logic [kgd_pkg::CNT_W-1:0] press_count_q   [KEY_DEPTH];
	logic [kgd_pkg::CNT_W-1:0] release_count_q [KEY_DEPTH];
	kgd_pkg::phase_t           key_phase_q     [KEY_DEPTH];
	logic                      shift_active_q;

	logic                      in_range;
	logic [IDX_W-1:0]          idx;
	logic [kgd_pkg::CNT_W-1:0] pc;
	logic [kgd_pkg::CNT_W-1:0] rc;
	kgd_pkg::phase_t           ph;
	logic                      sh_next;
	logic                      dbl_en;
	logic                      sh_en;
	logic                      rep_en;
	logic [kgd_pkg::CNT_W:0]   repeat_point;
	logic [1:0]                n;
	kgd_pkg::event_t           e0;
	kgd_pkg::event_t           e1;
	kgd_pkg::event_t           ev;

	assign in_range = {4'd0, key} < 7'(NUM_KEYS);
	assign idx      = key[IDX_W-1:0];
	assign dbl_en   = cfg.double_enable_mask[key];
	assign sh_en    = cfg.shift_enable_mask[key];
	assign rep_en   = cfg.repeat_enable_mask[key];
	assign repeat_point = {1'b0, cfg.long_press_ticks}
		+ {{(kgd_pkg::CNT_W + 1 - kgd_pkg::REP_W){1'b0}}, cfg.repeat_ticks};

	always_comb begin
		pc      = press_count_q[idx];
		rc      = release_count_q[idx];
		ph      = key_phase_q[idx];
		sh_next = shift_active_q;
		n       = 2'd0;
		ev      = '{key: key, kind: kgd_pkg::EV_PRESS, shifted: 1'b0};
		e0      = ev;
		e1      = ev;
		unique case (ph)
			kgd_pkg::PH_IDLE: begin
				if (pressed) begin
					if (rc >= cfg.confirm_ticks) begin
						pc = pc + 8'd1;
						if (pc >= cfg.confirm_ticks) begin
							ph = kgd_pkg::PH_PRESSED;
							if (dbl_en || sh_en) rc = '0;
						end
					end
				end else begin
					if (rc < cfg.confirm_ticks) rc = rc + 8'd1;
					pc = '0;
				end
			end
			kgd_pkg::PH_PRESSED: begin
				if (pressed) begin
					pc = pc + 8'd1;
					rc = '0;
					if (pc == cfg.long_press_ticks) begin
						ph = kgd_pkg::PH_LONG;
						if (sh_en) sh_next = 1'b1;
						e0 = '{key: key, kind: kgd_pkg::EV_LONG, shifted: 1'b0};
						n  = 2'd1;
					end
				end else begin
					rc = rc + 8'd1;
					// click press goes first, release may follow in the same sample
					if (pc >= kgd_pkg::MIN_PRESS_FOR_CLICK) begin
						e0 = '{key: key, kind: kgd_pkg::EV_PRESS, shifted: shift_active_q};
						n  = 2'd1;
						pc = '0;
					end
					if (rc >= cfg.confirm_ticks) begin
						if (dbl_en && pc < cfg.double_press_limit) begin
							ph = kgd_pkg::PH_WAIT_DOUBLE;
						end else begin
							ph = kgd_pkg::PH_IDLE;
							ev = '{key: key, kind: kgd_pkg::EV_RELEASE, shifted: shift_active_q};
							if (n == 2'd0) e0 = ev;
							else e1 = ev;
							n = n + 2'd1;
						end
						pc = '0;
					end
				end
			end
			kgd_pkg::PH_WAIT_DOUBLE: begin
				if (pressed) begin
					pc = pc + 8'd1;
					if (pc >= cfg.confirm_ticks) begin
						if (rc < cfg.double_gap_limit) begin
							ph = kgd_pkg::PH_IDLE;
							e0 = '{key: key, kind: kgd_pkg::EV_DOUBLE, shifted: 1'b0};
							n  = 2'd1;
						end
						rc = '0;
					end
				end else begin
					rc = rc + 8'd1;
					if (rc > cfg.double_gap_limit) begin
						ph = kgd_pkg::PH_IDLE;
						e0 = '{key: key, kind: kgd_pkg::EV_RELEASE, shifted: shift_active_q};
						n  = 2'd1;
					end
					pc = '0;
				end
			end
			kgd_pkg::PH_LONG: begin
				if (pressed) begin
					if (rep_en) begin
						pc = pc + 8'd1;
						// a repeat point above 255 never matches
						if ({1'b0, pc} == repeat_point) begin
							e0 = '{key: key, kind: kgd_pkg::EV_LONG, shifted: 1'b0};
							n  = 2'd1;
							pc = cfg.long_press_ticks;
						end
					end
					rc = '0;
				end else begin
					rc = rc + 8'd1;
					if (rc >= cfg.confirm_ticks) begin
						ph = kgd_pkg::PH_IDLE;
						if (sh_en) sh_next = 1'b0;
						e0 = '{key: key, kind: kgd_pkg::EV_LONG_RELEASE, shifted: 1'b0};
						n  = 2'd1;
						pc = '0;
					end
				end
			end
		endcase
		if (!in_range) n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_DEPTH; i++) begin
				press_count_q[i]   <= '0;
				release_count_q[i] <= '0;
				key_phase_q[i]     <= kgd_pkg::PH_IDLE;
			end
			shift_active_q <= 1'b0;
		end else if (step && in_range) begin
			press_count_q[idx]   <= pc;
			release_count_q[idx] <= rc;
			key_phase_q[idx]     <= ph;
			shift_active_q       <= sh_next;
		end
	end

	assign ev_cnt = n;
	assign ev0    = e0;
	assign ev1    = e1;

endmodule

`default_nettype wire

// ----- rtl/kgd_out_buf.sv -----
// kgd_out_buf: two entry result register holding the events of one sample
// depends on kgd_pkg for event_t
`default_nettype none

module kgd_out_buf (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic [1:0]      load_cnt,
	input  wire kgd_pkg::event_t load_ev0,
	input  wire kgd_pkg::event_t load_ev1,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output kgd_pkg::event_t      out_ev,
	output logic                 out_last
);

	logic [1:0]      cnt_q;
	kgd_pkg::event_t ev0_q;
	kgd_pkg::event_t ev1_q;
	logic            pop;

	assign out_valid = cnt_q != 2'd0;
	assign out_last  = cnt_q == 2'd1;
	assign out_ev    = ev0_q;
	assign pop       = out_valid && out_ready;
	// empty now, or the final beat leaves this cycle
	assign free      = (cnt_q == 2'd0) || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && free) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			ev0_q <= load_ev0;
			ev1_q <= load_ev1;
		end else if (pop) begin
			ev0_q <= ev1_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/key_gesture_detector_top.sv -----
// key_gesture_detector_top: per key debounce, click, long press, repeat and double click
// depends on kgd_pkg, kgd_cfg_regs, kgd_core and kgd_out_buf
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata[2:0] key_index, [3] pressed
//  m_*      out  m_tvalid/m_tready    m_tdata[2:0] event_key, [3] shifted; m_tuser event_kind;
//                                     m_tlast last event of a sample
//  cfg_*    in   cfg_we               cfg_index register, cfg_wdata value
//
// a sample beat is registered in stage 1, evaluated and written back to the key
// store when it advances; its zero to two events land in the result buffer at that edge
// one sample per cycle unless stalled; two events hold the output for two beats
// stage 1 waits while the result buffer still holds beats other than a final leaving one
// reset clears every key counter, phase and the shift flag at once; no clearing pass
`default_nettype none

module key_gesture_detector_top #(
	parameter int unsigned NUM_KEYS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// sample input
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [2:0] key_index, [3] pressed, [7:4] zero
	// event output
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [2:0] event_key, [3] shifted, [7:4] zero
	output logic [2:0]      m_tuser,   // [2:0] event_kind
	output logic            m_tlast,
	// configuration write port
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	kgd_pkg::cfg_t                 cfg;
	logic                          valid_s1;
	logic [kgd_pkg::KEY_W-1:0]     key_s1;
	logic                          pressed_s1;
	logic                          advance;
	logic                          buf_free;
	logic [1:0]                    ev_cnt;
	kgd_pkg::event_t               ev0;
	kgd_pkg::event_t               ev1;
	kgd_pkg::event_t               out_ev;

	kgd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// stage 1 moves on whenever the buffer can take its events
	assign advance  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1     <= s_tdata[2:0];
			pressed_s1 <= s_tdata[3];
		end
	end

	// key store and gesture rules, written back when the sample advances
	kgd_core #(
		.NUM_KEYS (NUM_KEYS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (advance),
		.key     (key_s1),
		.pressed (pressed_s1),
		.ev_cnt  (ev_cnt),
		.ev0     (ev0),
		.ev1     (ev1)
	);

	// result register, parts the output stall from the input side
	kgd_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_cnt  (ev_cnt),
		.load_ev0  (ev0),
		.load_ev1  (ev1),
		.free      (buf_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ev    (out_ev),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, out_ev.shifted, out_ev.key};
	assign m_tuser = out_ev.kind;

	// after the final beat of a sample the buffer is empty unless a new sample loaded
	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast && !advance |=> !m_tvalid)
		else $error("result buffer not empty after final beat");

	// a reload only replaces a buffer that is empty or emptying
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && m_tvalid |-> m_tlast && m_tready)
		else $error("result buffer overwritten");

	// only a click press precedes another event of the same sample
	a_first_is_press: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == kgd_pkg::EV_PRESS)
		else $error("non-final beat is not a press");

	// long, long release and double events never carry the shift flag
	a_shift_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == kgd_pkg::EV_LONG || m_tuser == kgd_pkg::EV_LONG_RELEASE
			|| m_tuser == kgd_pkg::EV_DOUBLE) |-> !m_tdata[3])
		else $error("shift flag on a kind that never carries it");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for key_gesture_detector_top, per key click, hold and double detection
// depends on kgd_pkg and the rtl; predicts every event in-line and compares beat by beat
`timescale 1ns / 100ps

module tb;

	localparam int unsigned KEY_COUNT     = 8;
	localparam int unsigned SETTLE_CYCLES = 8;       // pipeline depth plus margin
	localparam int unsigned CYCLE_LIMIT   = 200000;  // well above the slowest stalled run

	// one tick sample of one key
	typedef struct packed {
		logic [2:0] key;
		logic       pressed;
	} key_sample_t;

	// one predicted event beat
	typedef struct packed {
		logic [2:0]        key;
		kgd_pkg::ev_kind_t kind;
		logic              shifted;
		logic              last;
	} key_event_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'd0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_wdata = 8'd0;

	key_sample_t pending_samples[$];   // samples waiting for the driver
	key_event_t  expected_events[$];   // events predicted but not yet seen
	int unsigned queued_total   = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned src_idle_pct   = 0;
	int unsigned snk_idle_pct   = 0;
	logic        sample_taken   = 1'b0;

	// predictor copy of the register file, starting from reset values
	logic [7:0] confirm_lim   = 8'd3;
	logic [7:0] long_lim      = 8'd50;
	logic [5:0] repeat_gap    = 6'd10;
	logic [7:0] dbl_press_lim = 8'd15;
	logic [7:0] dbl_gap_lim   = 8'd15;
	logic [7:0] dbl_mask      = 8'h00;
	logic [7:0] shift_mask    = 8'h00;
	logic [7:0] rep_mask      = 8'h00;

	// predictor copy of the per key state
	logic [7:0]      hold_count [KEY_COUNT];
	logic [7:0]      gap_count  [KEY_COUNT];
	kgd_pkg::phase_t key_phase  [KEY_COUNT];
	logic            shift_held = 1'b0;

	initial begin
		for (int i = 0; i < KEY_COUNT; i++) begin
			hold_count[i] = 8'd0;
			gap_count[i]  = 8'd0;
			key_phase[i]  = kgd_pkg::PH_IDLE;
		end
	end

	key_gesture_detector_top #(
		.NUM_KEYS(KEY_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [2:0] key_index, [3] pressed
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [2:0] event_key, [3] shifted
		.m_tuser  (m_tuser),    // [2:0] event_kind
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// event prediction
	// ------------------------------------------------------------------

	function automatic void note_event(input logic [2:0] k, input kgd_pkg::ev_kind_t kind,
			input logic sh);
		key_event_t ev;
		ev.key     = k;
		ev.kind    = kind;
		ev.shifted = sh;
		ev.last    = 1'b0;
		expected_events.push_back(ev);
	endfunction

	// advance one key's debounce machine by one tick and queue its events
	task automatic track_key_sample(input logic [2:0] k, input logic down);
		logic [7:0]      pc;
		logic [7:0]      rc;
		kgd_pkg::phase_t ph;
		int unsigned     base;
		key_event_t      tail;
		pc   = hold_count[k];
		rc   = gap_count[k];
		ph   = key_phase[k];
		base = expected_events.size();
		case (ph)
		kgd_pkg::PH_IDLE: begin
			if (down) begin
				// a press only counts after enough quiet ticks
				if (rc >= confirm_lim) begin
					pc = pc + 8'd1;
					if (pc >= confirm_lim) begin
						ph = kgd_pkg::PH_PRESSED;
						if (dbl_mask[k] || shift_mask[k])
							rc = 8'd0;
					end
				end
			end else begin
				if (rc < confirm_lim)
					rc = rc + 8'd1;
				pc = 8'd0;
			end
		end
		kgd_pkg::PH_PRESSED: begin
			if (down) begin
				pc = pc + 8'd1;
				rc = 8'd0;
				if (pc == long_lim) begin
					ph = kgd_pkg::PH_LONG;
					if (shift_mask[k])
						shift_held = 1'b1;
					note_event(k, kgd_pkg::EV_LONG, 1'b0);
				end
			end else begin
				rc = rc + 8'd1;
				// press goes out on the first release tick of a real click
				if (pc >= kgd_pkg::MIN_PRESS_FOR_CLICK) begin
					note_event(k, kgd_pkg::EV_PRESS, shift_held);
					pc = 8'd0;
				end
				// release may follow in the same tick when confirm is tiny
				if (rc >= confirm_lim) begin
					if (dbl_mask[k] && pc < dbl_press_lim) begin
						ph = kgd_pkg::PH_WAIT_DOUBLE;
					end else begin
						ph = kgd_pkg::PH_IDLE;
						note_event(k, kgd_pkg::EV_RELEASE, shift_held);
					end
					pc = 8'd0;
				end
			end
		end
		kgd_pkg::PH_WAIT_DOUBLE: begin
			if (down) begin
				pc = pc + 8'd1;
				if (pc >= confirm_lim) begin
					if (rc < dbl_gap_lim) begin
						ph = kgd_pkg::PH_IDLE;
						note_event(k, kgd_pkg::EV_DOUBLE, 1'b0);
					end
					rc = 8'd0;
				end
			end else begin
				// release counter wraps when the gap limit is never exceeded
				rc = rc + 8'd1;
				if (rc > dbl_gap_lim) begin
					ph = kgd_pkg::PH_IDLE;
					note_event(k, kgd_pkg::EV_RELEASE, shift_held);
				end
				pc = 8'd0;
			end
		end
		default: begin
			if (down) begin
				if (rep_mask[k]) begin
					pc = pc + 8'd1;
					// sum at full width, so past 255 there is never a repeat
					if ({1'b0, pc} == {1'b0, long_lim} + {3'b000, repeat_gap}) begin
						note_event(k, kgd_pkg::EV_LONG, 1'b0);
						pc = long_lim;
					end
				end
				rc = 8'd0;
			end else begin
				rc = rc + 8'd1;
				if (rc >= confirm_lim) begin
					ph = kgd_pkg::PH_IDLE;
					if (shift_mask[k])
						shift_held = 1'b0;
					note_event(k, kgd_pkg::EV_LONG_RELEASE, 1'b0);
					pc = 8'd0;
				end
			end
		end
		endcase
		hold_count[k] = pc;
		gap_count[k]  = rc;
		key_phase[k]  = ph;
		// mark the final event of this sample
		if (expected_events.size() > base) begin
			tail      = expected_events.pop_back();
			tail.last = 1'b1;
			expected_events.push_back(tail);
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic check_event_beat();
		key_event_t want;
		if (expected_events.size() == 0) begin
			$error("event beat with nothing expected: key %0d kind %0d", m_tdata[2:0], m_tuser);
			mismatch_count++;
		end else begin
			want = expected_events.pop_front();
			compare_field("event_key", 8'(want.key), 8'(m_tdata[2:0]));
			compare_field("event_kind", 8'(want.kind), 8'(m_tuser));
			compare_field("shifted", 8'(want.shifted), 8'(m_tdata[3]));
			compare_field("last", 8'(want.last), 8'(m_tlast));
		end
	endtask

	// monitor: everything sampled at the rising edge
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		sample_taken = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_event_beat();
			if (s_tvalid && s_tready) begin
				sample_taken = 1'b1;
				track_key_sample(s_tdata[2:0], s_tdata[3]);
			end
		end
	end

	// driver: inputs change on the falling edge only
	always @(negedge clk) begin : sample_driver
		key_sample_t nxt;
		// a new beat goes up only once the previous one has been taken
		if (!s_tvalid || sample_taken) begin
			if (arst_n && pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_samples.pop_front();
				s_tdata  <= {4'd0, nxt.pressed, nxt.key};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_run(input logic [2:0] key, input logic level, input int unsigned n,
			input logic strays);
		key_sample_t smp;
		repeat (n) begin
			smp.key     = key;
			smp.pressed = level;
			pending_samples.push_back(smp);
			queued_total++;
			// now and then a sample of another key slips in between
			if (strays && $urandom_range(7) == 0) begin
				smp.key     = key + 3'($urandom_range(1, 7));
				smp.pressed = 1'($urandom_range(1));
				pending_samples.push_back(smp);
				queued_total++;
			end
		end
	endtask

	// one gesture on one key, sized from the current settings
	task automatic queue_gesture(input logic [2:0] key, input int unsigned max_shape);
		int unsigned c;
		int unsigned len;
		int unsigned gap;
		c   = (confirm_lim == 0) ? 1 : confirm_lim;
		gap = (dbl_gap_lim > 30) ? 30 : dbl_gap_lim;
		case ($urandom_range(max_shape))
		0: begin
			// line noise
			repeat ($urandom_range(1, 8))
				push_run(key, 1'($urandom_range(1)), 1, 1'b1);
		end
		1: begin
			// plain click
			push_run(key, 1'b0, c + $urandom_range(2), 1'b1);
			push_run(key, 1'b1, c + $urandom_range(3), 1'b1);
			push_run(key, 1'b0, c + $urandom_range(3), 1'b1);
		end
		2: begin
			// hold into long press, maybe a few repeats
			len = c + long_lim + repeat_gap * $urandom_range(3) + $urandom_range(2);
			if (len > 280)
				len = 280;
			push_run(key, 1'b0, c + 1, 1'b1);
			push_run(key, 1'b1, len, 1'b1);
			push_run(key, 1'b0, c + $urandom_range(2), 1'b1);
		end
		3: begin
			// two clicks with a random gap
			push_run(key, 1'b0, c + 1, 1'b1);
			push_run(key, 1'b1, c + $urandom_range(2), 1'b1);
			push_run(key, 1'b0, $urandom_range(1, gap + 1), 1'b1);
			push_run(key, 1'b1, c + $urandom_range(2), 1'b1);
			push_run(key, 1'b0, c + gap + 2, 1'b1);
		end
		default: begin
			// contact bounce before a settled press
			push_run(key, 1'b0, c + 1, 1'b1);
			repeat ($urandom_range(3, 8))
				push_run(key, 1'($urandom_range(1)), $urandom_range(1, 2), 1'b1);
			push_run(key, 1'b1, c + 2, 1'b1);
			push_run(key, 1'b0, c + 2, 1'b1);
		end
		endcase
	endtask

	task automatic random_gestures(input int unsigned budget, input int unsigned max_shape);
		int unsigned start;
		start = queued_total;
		while (queued_total - start < budget)
			queue_gesture(3'($urandom_range(7)), max_shape);
	endtask

	// block idle: all samples taken, all events seen, pipeline drained
	task automatic wait_quiet();
		while (pending_samples.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input kgd_pkg::cfg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		kgd_pkg::CFG_CONFIRM_TICKS:  confirm_lim   = val;
		kgd_pkg::CFG_LONG_TICKS:     long_lim      = val;
		kgd_pkg::CFG_REPEAT_TICKS:   repeat_gap    = val[5:0];
		kgd_pkg::CFG_DOUBLE_PRESS:   dbl_press_lim = val;
		kgd_pkg::CFG_DOUBLE_GAP:     dbl_gap_lim   = val;
		kgd_pkg::CFG_DOUBLE_EN_MASK: dbl_mask      = val;
		kgd_pkg::CFG_SHIFT_EN_MASK:  shift_mask    = val;
		default:                     rep_mask      = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input logic [7:0] confirm, input logic [7:0] long_ticks,
			input logic [7:0] rep, input logic [7:0] dpress, input logic [7:0] dgap,
			input logic [7:0] dmask, input logic [7:0] smask, input logic [7:0] rmask);
		write_reg(kgd_pkg::CFG_CONFIRM_TICKS, confirm);
		write_reg(kgd_pkg::CFG_LONG_TICKS, long_ticks);
		write_reg(kgd_pkg::CFG_REPEAT_TICKS, rep);
		write_reg(kgd_pkg::CFG_DOUBLE_PRESS, dpress);
		write_reg(kgd_pkg::CFG_DOUBLE_GAP, dgap);
		write_reg(kgd_pkg::CFG_DOUBLE_EN_MASK, dmask);
		write_reg(kgd_pkg::CFG_SHIFT_EN_MASK, smask);
		write_reg(kgd_pkg::CFG_REPEAT_EN_MASK, rmask);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------

	initial begin
		// sender mostly busy, receiver stalls often
		src_idle_pct = 16;
		snk_idle_pct = 70;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: clean click on the highest and the lowest key
		push_run(3'd7, 1'b0, 3, 1'b0);
		push_run(3'd7, 1'b1, 3, 1'b0);
		push_run(3'd7, 1'b0, 3, 1'b0);
		push_run(3'd0, 1'b0, 3, 1'b0);
		push_run(3'd0, 1'b1, 3, 1'b0);
		push_run(3'd0, 1'b0, 3, 1'b0);
		random_gestures(30, 4);

		// low extremes, double click on every key, zero gap
		wait_quiet();
		load_settings(8'd2, 8'd5, 8'd1, 8'd255, 8'd0, 8'hFF, 8'h0F, 8'hAA);
		random_gestures(45, 4);

		// mid values, repeat on every key
		wait_quiet();
		load_settings(8'd4, 8'd12, 8'd3, 8'd6, 8'd8, 8'h55, 8'h81, 8'hFF);
		random_gestures(45, 4);

		// receiver mostly ready, sender gappy
		wait_quiet();
		src_idle_pct = 70;
		snk_idle_pct = 16;

		// high extremes: nothing ever confirms, noise only
		load_settings(8'd255, 8'd200, 8'd55, 8'd0, 8'd254,
			8'($urandom), 8'($urandom), 8'($urandom));
		random_gestures(20, 0);

		// confirm of one: press and release out of a single sample,
		// repeat written with high bits set
		wait_quiet();
		load_settings(8'd1, 8'd3, 8'hFF, 8'd2, 8'd5, 8'hF0, 8'h3C, 8'h0F);
		random_gestures(30, 4);

		// all limits zero
		wait_quiet();
		load_settings(8'd0, 8'd0, 8'hC0, 8'd0, 8'd0, 8'h00, 8'hFF, 8'hFF);
		random_gestures(15, 1);

		// no idling on either side from here on
		wait_quiet();
		src_idle_pct = 0;
		snk_idle_pct = 0;

		// repeat point past 255 and counter wrap on a held shift key
		load_settings(8'd2, 8'd200, 8'd63, 8'd255, 8'd255, 8'h04, 8'h01, 8'h01);
		push_run(3'd0, 1'b0, 3, 1'b0);
		push_run(3'd0, 1'b1, 210, 1'b0);
		push_run(3'd1, 1'b0, 3, 1'b0);     // shifted click while key 0 is held
		push_run(3'd1, 1'b1, 3, 1'b0);
		push_run(3'd1, 1'b0, 3, 1'b0);
		push_run(3'd0, 1'b1, 60, 1'b0);
		push_run(3'd0, 1'b0, 3, 1'b0);

		// random settings within the usual ranges
		wait_quiet();
		load_settings(8'($urandom_range(2, 6)), 8'($urandom_range(5, 20)),
			8'($urandom_range(1, 8)), 8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
			8'($urandom), 8'($urandom), 8'($urandom));
		random_gestures(45, 4);

		wait_quiet();
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hang guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/kgd_pkg.sv
rtl/kgd_cfg_regs.sv
rtl/kgd_core.sv
rtl/kgd_out_buf.sv
rtl/key_gesture_detector_top.sv
bench/tb.sv
